// ----- hw/rtl/cnt_pkg.sv -----
// Shared types and constants for the normalization cube map texel pipeline.
// No dependencies; used by cnt_front, cnt_step and cube_normal_texel.

package cnt_pkg;

	localparam int LANES = 3;
	localparam int STEPS = 8;
	localparam int FRONT_STAGES = 3;
	localparam int STEP_STAGES = 3;
	localparam int Q_SCALE = 254;

	localparam logic [7:0] V_MAX = 8'd254;
	localparam logic [7:0] V_MID = 8'd127;
	localparam logic [7:0] V_HALF = 8'd128;
	localparam logic [8:0] P_BIAS = 9'd255;

	typedef enum logic [2:0] {
		FACE_POS_X = 3'd0,
		FACE_NEG_X = 3'd1,
		FACE_POS_Y = 3'd2,
		FACE_NEG_Y = 3'd3,
		FACE_POS_Z = 3'd4,
		FACE_NEG_Z = 3'd5
	} face_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} stage_en_t;

endpackage

// ----- hw/rtl/cnt_front.sv -----
// Front end of the texel pipeline: face direction, squared length and squared targets.
// Three register stages. Depends on cnt_pkg.

module cnt_front #(
	parameter int FACE_SIZE = 128,
	parameter int MAG_W = 8
) (
	input  logic                  clk,
	input  cnt_pkg::stage_en_t    en,
	input  logic [2:0]            face,
	input  logic [6:0]            column,
	input  logic [6:0]            row,
	output logic [2*MAG_W+1:0]    s_s3,
	output logic [7:0]            lo_s3 [cnt_pkg::LANES],
	output logic [7:0]            hi_s3 [cnt_pkg::LANES],
	output logic                  neg_s3 [cnt_pkg::LANES],
	output logic [2*MAG_W+15:0]   q2_s3 [cnt_pkg::LANES]
);

	localparam int CW = MAG_W + 1;
	localparam int SQ_W = 2 * MAG_W;
	localparam int S_W = SQ_W + 2;
	localparam int Q_W = MAG_W + 8;
	localparam int Q2_W = 2 * Q_W;
	localparam logic signed [CW-1:0] D = CW'(FACE_SIZE - 1);

	logic signed [CW-1:0] a, b;
	logic signed [CW-1:0] vec [cnt_pkg::LANES];
	logic signed [CW-1:0] vec_s1 [cnt_pkg::LANES];

	logic [SQ_W-1:0] sq_s2 [cnt_pkg::LANES];
	logic [Q_W-1:0]  qm_s2 [cnt_pkg::LANES];
	logic            neg_s2 [cnt_pkg::LANES];

	logic zero;

	assign a = $signed(CW'({column, 1'b0})) - D;
	assign b = $signed(CW'({row, 1'b0})) - D;

	always_comb begin
		vec[0] = '0;
		vec[1] = '0;
		vec[2] = '0;
		unique case (face)
			cnt_pkg::FACE_POS_X: begin
				vec[0] = D;  vec[1] = -b; vec[2] = -a;
			end
			cnt_pkg::FACE_NEG_X: begin
				vec[0] = -D; vec[1] = -b; vec[2] = a;
			end
			cnt_pkg::FACE_POS_Y: begin
				vec[0] = a;  vec[1] = D;  vec[2] = b;
			end
			cnt_pkg::FACE_NEG_Y: begin
				vec[0] = a;  vec[1] = -D; vec[2] = -b;
			end
			cnt_pkg::FACE_POS_Z: begin
				vec[0] = a;  vec[1] = -b; vec[2] = D;
			end
			cnt_pkg::FACE_NEG_Z: begin
				vec[0] = -a; vec[1] = -b; vec[2] = -D;
			end
			default: begin
				vec[0] = '0; vec[1] = '0; vec[2] = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			vec_s1 <= vec;
		end
	end

	// stage 2: magnitude, square, scaled target
	for (genvar i = 0; i < cnt_pkg::LANES; i++) begin : g_lane2
		logic              neg;
		logic signed [CW-1:0] absv;
		logic [SQ_W-1:0]   mag_x;
		logic [Q_W-1:0]    mag_q;

		assign neg   = vec_s1[i][CW-1];
		assign absv  = neg ? -vec_s1[i] : vec_s1[i];
		assign mag_x = SQ_W'(absv[MAG_W-1:0]);
		assign mag_q = Q_W'(absv[MAG_W-1:0]);

		always_ff @(posedge clk) begin
			if (en.s2) begin
				sq_s2[i]  <= mag_x * mag_x;
				qm_s2[i]  <= mag_q * Q_W'(cnt_pkg::Q_SCALE);
				neg_s2[i] <= neg;
			end
		end
	end

	// stage 3: squared length, squared targets, search bounds
	assign zero = ((sq_s2[0] | sq_s2[1] | sq_s2[2]) == '0);

	for (genvar i = 0; i < cnt_pkg::LANES; i++) begin : g_lane3
		logic [Q2_W-1:0] qm_x;

		assign qm_x = Q2_W'(qm_s2[i]);

		always_ff @(posedge clk) begin
			if (en.s3) begin
				q2_s3[i]  <= qm_x * qm_x;
				neg_s3[i] <= neg_s2[i];
				lo_s3[i]  <= zero ? cnt_pkg::V_MID : '0;
				hi_s3[i]  <= zero ? cnt_pkg::V_MID : cnt_pkg::V_MAX;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			s_s3 <= S_W'(sq_s2[0]) + S_W'(sq_s2[1]) + S_W'(sq_s2[2]);
		end
	end

endmodule

// ----- hw/rtl/cnt_step.sv -----
// One bisection step of the encode search for all three components.
// Three register stages: offset square, scale by length, compare and narrow. Depends on cnt_pkg.

module cnt_step #(
	parameter int MAG_W = 8
) (
	input  logic                  clk,
	input  cnt_pkg::stage_en_t    en,
	input  logic [2*MAG_W+1:0]    s,
	input  logic [7:0]            lo [cnt_pkg::LANES],
	input  logic [7:0]            hi [cnt_pkg::LANES],
	input  logic                  neg [cnt_pkg::LANES],
	input  logic [2*MAG_W+15:0]   q2 [cnt_pkg::LANES],
	output logic [2*MAG_W+1:0]    s_s3,
	output logic [7:0]            lo_s3 [cnt_pkg::LANES],
	output logic [7:0]            hi_s3 [cnt_pkg::LANES],
	output logic                  neg_s3 [cnt_pkg::LANES],
	output logic [2*MAG_W+15:0]   q2_s3 [cnt_pkg::LANES]
);

	localparam int S_W = 2 * MAG_W + 2;
	localparam int Q2_W = 2 * MAG_W + 16;
	localparam int PS_W = S_W + 16;

	logic [S_W-1:0] s_s1, s_s2;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			s_s1 <= s;
		end
		if (en.s2) begin
			s_s2 <= s_s1;
		end
		if (en.s3) begin
			s_s3 <= s_s2;
		end
	end

	for (genvar i = 0; i < cnt_pkg::LANES; i++) begin : g_lane
		logic [8:0]      sum;
		logic [7:0]      mid;
		logic            pos;
		logic [8:0]      m2, pm9;
		logic [15:0]     pm_x;

		logic [7:0]      lo_s1, hi_s1, mid_s1;
		logic            pos_s1, neg_s1;
		logic [15:0]     p2_s1;
		logic [Q2_W-1:0] q2_s1;

		logic [7:0]      lo_s2, hi_s2, mid_s2;
		logic            pos_s2, neg_s2;
		logic [PS_W-1:0] prod_s2;
		logic [Q2_W-1:0] q2_s2;

		logic [PS_W-1:0] q2_x;
		logic            take;
		logic            open;
		logic [7:0]      lo_nx, hi_nx;

		// offset p = 2*mid - 255, odd and nonzero
		assign sum  = 9'(lo[i]) + 9'(hi[i]) + 9'd1;
		assign mid  = sum[8:1];
		assign pos  = (mid >= cnt_pkg::V_HALF);
		assign m2   = {mid, 1'b0};
		assign pm9  = pos ? (m2 - cnt_pkg::P_BIAS) : (cnt_pkg::P_BIAS - m2);
		assign pm_x = 16'(pm9[7:0]);

		always_ff @(posedge clk) begin
			if (en.s1) begin
				lo_s1  <= lo[i];
				hi_s1  <= hi[i];
				mid_s1 <= mid;
				pos_s1 <= pos;
				neg_s1 <= neg[i];
				q2_s1  <= q2[i];
				p2_s1  <= pm_x * pm_x;
			end
		end

		always_ff @(posedge clk) begin
			if (en.s2) begin
				lo_s2   <= lo_s1;
				hi_s2   <= hi_s1;
				mid_s2  <= mid_s1;
				pos_s2  <= pos_s1;
				neg_s2  <= neg_s1;
				q2_s2   <= q2_s1;
				prod_s2 <= PS_W'(p2_s1) * PS_W'(s_s1);
			end
		end

		// p*sqrt(S) <= 254*c, decided on squares with signs
		assign q2_x = PS_W'(q2_s2);
		assign take = pos_s2 ? (!neg_s2 && (prod_s2 <= q2_x))
		                     : (!neg_s2 || (prod_s2 >= q2_x));

		assign open  = (lo_s2 < hi_s2);
		assign lo_nx = (open && take) ? mid_s2 : lo_s2;
		assign hi_nx = (open && !take) ? (mid_s2 - 8'd1) : hi_s2;

		always_ff @(posedge clk) begin
			if (en.s3) begin
				neg_s3[i] <= neg_s2;
				q2_s3[i]  <= q2_s2;
				lo_s3[i]  <= lo_nx;
				hi_s3[i]  <= hi_nx;
			end
		end
	end

endmodule

// ----- hw/rtl/cube_normal_texel.sv -----
// Top level of the normalization cube map texel pipeline: stage control and output register.
// Depends on cnt_pkg, cnt_front and cnt_step.

// Maps a cube face and texel column/row to the normalized direction through the texel
// center, each component encoded as round(127 + 127*c/|v|) in 0..254 (ties upward). Faces
// six and seven give 127 on all three channels. One coordinate transfer per clock is taken
// and one color transfer per clock is produced while color_stall is low, through three front
// stages (direction, squares, length and squared targets), eight bisection steps of three
// stages each (offset square, multiply by squared length, compare), and the output register.
// Stages with no item collapse under a color stall, so coord_stall rises only when every
// stage and the output register hold an item. FACE_SIZE may range from 2 to 128.

module cube_normal_texel #(
	parameter int FACE_SIZE = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       coord_valid,
	output logic       coord_stall,
	input  logic [2:0] face,
	input  logic [6:0] column,
	input  logic [6:0] row,
	output logic       color_valid,
	input  logic       color_stall,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue
);

	localparam int MAG_W = $clog2(FACE_SIZE > 256 ? FACE_SIZE : 256);
	localparam int S_W = 2 * MAG_W + 2;
	localparam int Q2_W = 2 * MAG_W + 16;
	localparam int NST = cnt_pkg::FRONT_STAGES + cnt_pkg::STEPS * cnt_pkg::STEP_STAGES;

	logic [NST-1:0] v_q;
	logic [NST-1:0] v_next;
	logic [NST:0]   adv;
	logic           out_v_q;
	logic [7:0]     red_q, green_q, blue_q;

	logic [S_W-1:0]  s_c   [cnt_pkg::STEPS+1];
	logic [7:0]      lo_c  [cnt_pkg::STEPS+1][cnt_pkg::LANES];
	logic [7:0]      hi_c  [cnt_pkg::STEPS+1][cnt_pkg::LANES];
	logic            neg_c [cnt_pkg::STEPS+1][cnt_pkg::LANES];
	logic [Q2_W-1:0] q2_c  [cnt_pkg::STEPS+1][cnt_pkg::LANES];

	// a stage loads when it is empty or the stages after it have room
	assign adv[NST] = !out_v_q || !color_stall;
	for (genvar k = 0; k < NST; k++) begin : g_adv
		assign adv[k] = adv[NST] || !(&v_q[NST-1:k]);
	end

	assign coord_stall = !adv[0];
	assign v_next = {v_q[NST-2:0], coord_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q     <= '0;
			out_v_q <= 1'b0;
		end else begin
			for (int k = 0; k < NST; k++) begin
				if (adv[k]) begin
					v_q[k] <= v_next[k];
				end
			end
			if (adv[NST]) begin
				out_v_q <= v_q[NST-1];
			end
		end
	end

	cnt_front #(
		.FACE_SIZE (FACE_SIZE),
		.MAG_W     (MAG_W)
	) u_front (
		.clk    (clk),
		.en     ('{s1: adv[0], s2: adv[1], s3: adv[2]}),
		.face   (face),
		.column (column),
		.row    (row),
		.s_s3   (s_c[0]),
		.lo_s3  (lo_c[0]),
		.hi_s3  (hi_c[0]),
		.neg_s3 (neg_c[0]),
		.q2_s3  (q2_c[0])
	);

	for (genvar j = 0; j < cnt_pkg::STEPS; j++) begin : g_step
		localparam int B = cnt_pkg::FRONT_STAGES + j * cnt_pkg::STEP_STAGES;

		cnt_step #(
			.MAG_W (MAG_W)
		) u_step (
			.clk    (clk),
			.en     ('{s1: adv[B], s2: adv[B+1], s3: adv[B+2]}),
			.s      (s_c[j]),
			.lo     (lo_c[j]),
			.hi     (hi_c[j]),
			.neg    (neg_c[j]),
			.q2     (q2_c[j]),
			.s_s3   (s_c[j+1]),
			.lo_s3  (lo_c[j+1]),
			.hi_s3  (hi_c[j+1]),
			.neg_s3 (neg_c[j+1]),
			.q2_s3  (q2_c[j+1])
		);
	end

	always_ff @(posedge clk) begin
		if (adv[NST]) begin
			red_q   <= lo_c[cnt_pkg::STEPS][0];
			green_q <= lo_c[cnt_pkg::STEPS][1];
			blue_q  <= lo_c[cnt_pkg::STEPS][2];
		end
	end

	assign color_valid = out_v_q;
	assign red         = red_q;
	assign green       = green_q;
	assign blue        = blue_q;

	// items in flight change only by a transfer on either side
	a_conserve: assert property (@(posedge clk) disable iff (!arst_n)
		!(coord_valid && !coord_stall) && !(color_valid && !color_stall)
		|=> $countones({v_q, out_v_q}) == $past($countones({v_q, out_v_q})))
		else $error("item count changed without a transfer");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		coord_stall |-> (color_valid && color_stall && (&v_q)))
		else $error("input stalled with a free stage");

	a_converged: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[NST-1] |-> (lo_c[cnt_pkg::STEPS][0] == hi_c[cnt_pkg::STEPS][0])
		            && (lo_c[cnt_pkg::STEPS][1] == hi_c[cnt_pkg::STEPS][1])
		            && (lo_c[cnt_pkg::STEPS][2] == hi_c[cnt_pkg::STEPS][2]))
		else $error("search not converged at last step");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		color_valid |-> (red <= cnt_pkg::V_MAX) && (green <= cnt_pkg::V_MAX)
		             && (blue <= cnt_pkg::V_MAX))
		else $error("color component out of range");

endmodule
